@@ hw/rtl/wscc_pkg.sv @@
// shared types, constants and codes for the wheel speed and cadence capture block
`default_nettype none

package wscc_pkg;

  localparam int TIMER_WIDTH_DEF      = 32;
  localparam int WRAP_COUNT_WIDTH_DEF = 8;

  localparam int NUM_WIDTH       = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int LIMIT_WIDTH     = 8;
  localparam int MARGIN_WIDTH    = 16;
  localparam int Q8_WIDTH        = 16;
  localparam int REV_WIDTH       = 32;
  localparam int CAP_WIDTH       = 32;
  localparam int CMD_DEPTH       = 4;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPEED_NUM    = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CADENCE_NUM  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMER_RELOAD = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WRAP_LIMIT   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GLITCH       = 3'd4;

  localparam logic [1:0] MODE_WHEEL = 2'd0;
  localparam logic [1:0] MODE_CRANK = 2'd1;
  localparam logic [1:0] MODE_WRAP  = 2'd2;

  localparam logic [NUM_WIDTH-1:0]    RESET_TIMER_RELOAD = '1;
  localparam logic [LIMIT_WIDTH-1:0]  RESET_WRAP_LIMIT   = 8'd3;
  localparam logic [MARGIN_WIDTH-1:0] RESET_GLITCH       = 16'd12800;

  typedef enum logic [1:0] {
    K_WHEEL,
    K_CRANK,
    K_WRAP,
    K_NONE
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_DIV,
    ST_COMMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [CAP_WIDTH-1:0] capture_value;
    logic                 recording_on;
  } in_item_t;

  typedef struct packed {
    logic [Q8_WIDTH-1:0]  speed_q8;
    logic [Q8_WIDTH-1:0]  max_speed_q8;
    logic [Q8_WIDTH-1:0]  cadence_q8;
    logic [REV_WIDTH-1:0] wheel_revolutions;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CAP_WIDTH-1:0] capture;
    logic                 recording;
  } cmd_t;

  function automatic logic [Q8_WIDTH-1:0] sat_q8(input logic [NUM_WIDTH-1:0] q);
    logic [Q8_WIDTH-1:0] r;
    if (q[NUM_WIDTH-1:Q8_WIDTH] != '0) begin
      r = '1;
    end else begin
      r = q[Q8_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wscc_front.sv @@
// front end: takes events, decodes their kind and queues them for the back end
`default_nettype none

module wscc_front import wscc_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item,
  input  wire logic     cmd_pop,
  output logic          cmd_empty,
  output cmd_t          cmd
);

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             slots [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             decoded;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    case (item.mode)
      MODE_WHEEL: decoded.kind = K_WHEEL;
      MODE_CRANK: decoded.kind = K_CRANK;
      MODE_WRAP:  decoded.kind = K_WRAP;
      default:    decoded.kind = K_NONE;
    endcase
    // capture counts live modulo the timer width
    decoded.capture   = CAP_WIDTH'(item.capture_value[TIMER_WIDTH-1:0]);
    decoded.recording = item.recording_on;
  end

  assign full      = (count == CNT_W'(CMD_DEPTH));
  assign cmd_empty = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && !cmd_empty;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wscc_div.sv @@
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module wscc_div import wscc_pkg::*; #(
  parameter int DIVISOR_WIDTH = NUM_WIDTH + 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [NUM_WIDTH-1:0]     dividend,
  input  wire logic [DIVISOR_WIDTH-1:0] divisor,
  output logic                          done,
  output logic [NUM_WIDTH-1:0]          quotient
);

  localparam int CNT_W = $clog2(NUM_WIDTH);
  localparam int CMP_W = (DIVISOR_WIDTH > NUM_WIDTH + 1) ? DIVISOR_WIDTH : NUM_WIDTH + 1;

  logic                     busy;
  logic [CNT_W-1:0]         cnt;
  logic [NUM_WIDTH:0]       rem;
  logic [NUM_WIDTH-1:0]     dq;
  logic [DIVISOR_WIDTH-1:0] dsr;
  logic [NUM_WIDTH:0]       rem_sh;
  logic [CMP_W-1:0]         rem_ext;
  logic [CMP_W-1:0]         dsr_ext;
  logic [CMP_W-1:0]         diff;
  logic                     fits;

  always_comb begin
    rem_sh  = {rem[NUM_WIDTH-1:0], dq[NUM_WIDTH-1]};
    rem_ext = CMP_W'(rem_sh);
    dsr_ext = CMP_W'(dsr);
    fits    = (rem_ext >= dsr_ext);
    diff    = rem_ext - dsr_ext;
  end

  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[NUM_WIDTH:0] : rem_sh;
      dq  <= {dq[NUM_WIDTH-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wscc_back.sv @@
// back end: configuration, measurement state, period and quotient sequencing, result slot
`default_nettype none

module wscc_back import wscc_pkg::*; #(
  parameter int TIMER_WIDTH      = TIMER_WIDTH_DEF,
  parameter int WRAP_COUNT_WIDTH = WRAP_COUNT_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                       cmd_empty,
  input  wire cmd_t                       cmd,
  output logic                            cmd_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output out_item_t                       result
);

  localparam int TW    = TIMER_WIDTH;
  localparam int WW    = WRAP_COUNT_WIDTH;
  localparam int PW    = WW + NUM_WIDTH;
  localparam int TKW   = PW + 1;
  localparam int LIM_W = (WW > LIMIT_WIDTH) ? WW : LIMIT_WIDTH;

  // configuration
  logic [NUM_WIDTH-1:0]    speed_numerator;
  logic [NUM_WIDTH-1:0]    cadence_numerator;
  logic [NUM_WIDTH-1:0]    timer_reload;
  logic [LIMIT_WIDTH-1:0]  wrap_limit;
  logic [MARGIN_WIDTH-1:0] glitch_margin;

  // measurement state
  logic [TW-1:0]        wheel_last;
  logic                 wheel_have_prev;
  logic [WW-1:0]        wheel_wraps;
  logic [Q8_WIDTH-1:0]  speed_value;
  logic [Q8_WIDTH-1:0]  speed_peak;
  logic [TW-1:0]        crank_first;
  logic                 crank_phase;
  logic [WW-1:0]        crank_wraps;
  logic [Q8_WIDTH-1:0]  cadence_value;
  logic [REV_WIDTH-1:0] rev_count;

  logic [TW-1:0]        wheel_last_next;
  logic                 wheel_have_prev_next;
  logic [WW-1:0]        wheel_wraps_next;
  logic [Q8_WIDTH-1:0]  speed_value_next;
  logic [Q8_WIDTH-1:0]  speed_peak_next;
  logic [TW-1:0]        crank_first_next;
  logic                 crank_phase_next;
  logic [WW-1:0]        crank_wraps_next;
  logic [Q8_WIDTH-1:0]  cadence_value_next;
  logic [REV_WIDTH-1:0] rev_count_next;

  back_state_t          state;
  back_state_t          state_next;
  cmd_t                 cur;
  logic [PW-1:0]        prod;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_quot;
  logic                 commit;
  logic                 out_valid;
  logic                 out_free;
  logic                 measure;

  logic [TW-1:0]        cur_cap;
  logic [TW-1:0]        sel_last;
  logic [WW-1:0]        sel_wraps;
  logic [NUM_WIDTH-1:0] sel_num;
  logic [TW-1:0]        short_diff;
  logic [TKW-1:0]       long_sum;
  logic [TKW-1:0]       then_ext;
  logic [TKW-1:0]       ticks;
  logic [Q8_WIDTH-1:0]  cand;
  logic [Q8_WIDTH:0]    speed_limit;
  logic [WW-1:0]        wheel_wraps_inc;
  logic [WW-1:0]        crank_wraps_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_numerator   <= '0;
      cadence_numerator <= '0;
      timer_reload      <= RESET_TIMER_RELOAD;
      wrap_limit        <= RESET_WRAP_LIMIT;
      glitch_margin     <= RESET_GLITCH;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SPEED_NUM:    speed_numerator   <= cfg_data;
        CFG_CADENCE_NUM:  cadence_numerator <= cfg_data;
        CFG_TIMER_RELOAD: timer_reload      <= cfg_data;
        CFG_WRAP_LIMIT:   wrap_limit        <= cfg_data[LIMIT_WIDTH-1:0];
        CFG_GLITCH:       glitch_margin     <= cfg_data[MARGIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign measure  = (cmd.kind == K_WHEEL && wheel_have_prev) ||
                    (cmd.kind == K_CRANK && crank_phase);

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          state_next = measure ? ST_MUL : ST_COMMIT;
        end
      end
      ST_MUL: begin
        state_next = ST_SUB;
      end
      ST_SUB: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // channel operands of the item in flight
  always_comb begin
    cur_cap   = cur.capture[TW-1:0];
    sel_last  = (cur.kind == K_WHEEL) ? wheel_last : crank_first;
    sel_wraps = (cur.kind == K_WHEEL) ? wheel_wraps : crank_wraps;
    sel_num   = (cur.kind == K_WHEEL) ? speed_numerator : cadence_numerator;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state == ST_MUL) begin
      prod <= PW'(sel_wraps) * PW'(timer_reload);
    end
  end

  // period in ticks, clamped at zero when the wrap-extended count falls short
  always_comb begin
    short_diff = cur_cap - sel_last;
    long_sum   = TKW'(cur_cap) + TKW'(prod);
    then_ext   = TKW'(sel_last);
    if (sel_wraps == '0) begin
      ticks = TKW'(short_diff);
    end else if (long_sum >= then_ext) begin
      ticks = long_sum - then_ext;
    end else begin
      ticks = '0;
    end
  end

  wscc_div #(
    .DIVISOR_WIDTH(TKW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sel_num),
    .divisor  (ticks),
    .done     (div_done),
    .quotient (div_quot)
  );

  // zero ticks gives an all-ones quotient, which saturates as required
  assign cand            = sat_q8(div_quot);
  assign speed_limit     = {1'b0, speed_value} + {1'b0, glitch_margin};
  assign wheel_wraps_inc = (wheel_wraps == '1) ? wheel_wraps : wheel_wraps + 1'b1;
  assign crank_wraps_inc = (crank_wraps == '1) ? crank_wraps : crank_wraps + 1'b1;

  always_comb begin
    wheel_last_next      = wheel_last;
    wheel_have_prev_next = wheel_have_prev;
    wheel_wraps_next     = wheel_wraps;
    speed_value_next     = speed_value;
    speed_peak_next      = speed_peak;
    crank_first_next     = crank_first;
    crank_phase_next     = crank_phase;
    crank_wraps_next     = crank_wraps;
    cadence_value_next   = cadence_value;
    rev_count_next       = rev_count;
    case (cur.kind)
      K_WHEEL: begin
        if (cur.recording) begin
          rev_count_next = rev_count + 1'b1;
        end
        if (wheel_have_prev) begin
          if ({1'b0, cand} < speed_limit) begin
            speed_value_next = cand;
          end
          if (speed_peak < speed_value_next) begin
            speed_peak_next = speed_value_next;
          end
        end
        wheel_last_next      = cur_cap;
        wheel_have_prev_next = 1'b1;
        wheel_wraps_next     = '0;
      end
      K_CRANK: begin
        if (crank_phase) begin
          cadence_value_next = cand;
          crank_phase_next   = 1'b0;
        end else begin
          crank_first_next = cur_cap;
          crank_phase_next = 1'b1;
        end
        crank_wraps_next = '0;
      end
      K_WRAP: begin
        wheel_wraps_next = wheel_wraps_inc;
        crank_wraps_next = crank_wraps_inc;
        if (LIM_W'(wheel_wraps_inc) > LIM_W'(wrap_limit)) begin
          wheel_have_prev_next = 1'b0;
          speed_value_next     = '0;
        end
        if (LIM_W'(crank_wraps_inc) > LIM_W'(wrap_limit)) begin
          crank_phase_next   = 1'b0;
          cadence_value_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_last      <= '0;
      wheel_have_prev <= 1'b0;
      wheel_wraps     <= '0;
      speed_value     <= '0;
      speed_peak      <= '0;
      crank_first     <= '0;
      crank_phase     <= 1'b0;
      crank_wraps     <= '0;
      cadence_value   <= '0;
      rev_count       <= '0;
    end else if (commit) begin
      wheel_last      <= wheel_last_next;
      wheel_have_prev <= wheel_have_prev_next;
      wheel_wraps     <= wheel_wraps_next;
      speed_value     <= speed_value_next;
      speed_peak      <= speed_peak_next;
      crank_first     <= crank_first_next;
      crank_phase     <= crank_phase_next;
      crank_wraps     <= crank_wraps_next;
      cadence_value   <= cadence_value_next;
      rev_count       <= rev_count_next;
    end
  end

  // one-entry result slot
  always_ff @(posedge clk) begin
    if (commit) begin
      result.speed_q8          <= speed_value_next;
      result.max_speed_q8      <= speed_peak_next;
      result.cadence_q8        <= cadence_value_next;
      result.wheel_revolutions <= rev_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wheel_speed_cadence_capture.sv @@
// top level of the wheel speed and pedal cadence capture block
// Usage:
//   Events enter through a queue-style port: drive item and raise push; the
//   transaction happens at a clock edge with push high and full low. Each
//   event is a wheel capture, a crank capture or a timer wrap.
//   Every event yields one result (speed, peak speed, cadence, revolutions)
//   on the result port; it is taken at an edge with pop high and empty low.
//   Registers are written through cfg_write/cfg_index/cfg_data at any edge,
//   and should only change while no event is in flight.
// Timing:
//   A four-entry event queue decouples the input from the execution unit.
//   Captures that measure a period pass through these back end steps in
//   order: take the event, form the wraps times reload product, compute
//   the period, run the serial divider (one quotient bit per cycle) and
//   commit. Other events go straight from taking the event to the commit.
//   A result waits in a one-entry slot while pop is low; the back end then
//   holds its next event and the queue fills until full rises.
// Reset: synchronous rst clears control state and loads register defaults.
`default_nettype none

module wheel_speed_cadence_capture import wscc_pkg::*; #(
  parameter int TIMER_WIDTH      = TIMER_WIDTH_DEF,
  parameter int WRAP_COUNT_WIDTH = WRAP_COUNT_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire in_item_t                   item,
  output logic                            empty,
  input  wire logic                       pop,
  output out_item_t                       result,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd;

  wscc_front #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  wscc_back #(
    .TIMER_WIDTH      (TIMER_WIDTH),
    .WRAP_COUNT_WIDTH (WRAP_COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire
